[rtl/acma_pkg.sv]
// ---------------------------------------------------------------------------
// acma_pkg
// shared types and constants of the channel moving average filter
// ---------------------------------------------------------------------------
package acma_pkg;

  localparam int RawW = 16;
  localparam int RefW = 16;
  localparam int ResW = 5;
  localparam int ResLimit = 16;

  // register indexes
  localparam int RegRef = 0;
  localparam int RegRes = 1;

  // divider sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MV0,
    ST_MV1,
    ST_DONE
  } state_t;

endpackage

[rtl/acma_divider.sv]
// ---------------------------------------------------------------------------
// acma_divider
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module acma_divider import acma_pkg::*; #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};

  // shift and subtract step
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      q    <= num;
      d    <= den;
      rem  <= '0;
      cnt  <= CntW'(NUM_W);
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quot = q;

endmodule

[rtl/acma_front.sv]
// ---------------------------------------------------------------------------
// acma_front
// channel filter, ring store and running sums; queues work to the back end
// ---------------------------------------------------------------------------
module acma_front import acma_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_channel,
  input  logic [RawW-1:0]     in_raw,
  output logic                q_valid,
  input  logic                q_ready,
  output logic [1:0]          q_channel,
  output logic [RawW-1:0]     q_raw,
  output logic [RawW+7:0]     q_sum,
  output logic [7:0]          q_cnt
);

  localparam int PosW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ChW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SumW = RawW + 8;
  localparam int IdxW = (CHANNELS * WINDOW > 1) ? $clog2(CHANNELS * WINDOW) : 1;

  // ring memory, one row per channel
  logic [RawW-1:0] ring [CHANNELS*WINDOW];
  logic [SumW-1:0] sums [CHANNELS];
  logic [PosW-1:0] wpos [CHANNELS];
  logic [7:0]      fill [CHANNELS];

  // two stage: read ring, then update
  logic            s1_valid;
  logic [1:0]      s1_ch;
  logic [RawW-1:0] s1_raw;
  logic [RawW-1:0] s1_old;
  logic [ChW-1:0]  ci, si;
  logic [PosW-1:0] pos;
  logic            full;
  logic [SumW-1:0] new_sum;
  logic [7:0]      new_cnt;
  logic [IdxW-1:0] rd_idx, wr_idx;

  // one entry output queue
  logic qv;
  assign q_valid  = qv;
  assign in_ready = !s1_valid && !qv;

  assign ci  = ChW'(in_channel);
  assign si  = ChW'(s1_ch);
  assign pos = wpos[si];
  assign full = fill[si] >= 8'(WINDOW);
  assign new_sum = sums[si] - (full ? SumW'(s1_old) : '0) + SumW'(s1_raw);
  assign new_cnt = full ? 8'(WINDOW) : fill[si] + 8'd1;
  assign rd_idx = IdxW'(ci * WINDOW + int'(wpos[ci]));
  assign wr_idx = IdxW'(si * WINDOW + int'(pos));

  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      s1_old <= ring[rd_idx];
    if (s1_valid)
      ring[wr_idx] <= s1_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      qv <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sums[i] <= '0;
        wpos[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (q_valid && q_ready) qv <= 1'b0;
      s1_valid <= 1'b0;
      if (in_valid && in_ready && (32'(in_channel) < CHANNELS)) begin
        s1_valid <= 1'b1;
        s1_ch    <= in_channel;
        s1_raw   <= in_raw;
      end
      if (s1_valid) begin
        sums[si] <= new_sum;
        fill[si] <= new_cnt;
        wpos[si] <= (32'(pos) == WINDOW - 1) ? '0 : pos + 1'b1;
        qv        <= 1'b1;
        q_channel <= s1_ch;
        q_raw     <= s1_raw;
        q_sum     <= new_sum;
        q_cnt     <= new_cnt;
      end
    end
  end

endmodule

[rtl/acma_back.sv]
// ---------------------------------------------------------------------------
// acma_back
// average and millivolt scaling over a shared divider, output register
// ---------------------------------------------------------------------------
module acma_back import acma_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [RefW-1:0] ref_mv,
  input  logic [ResW-1:0] res_bits,
  input  logic            q_valid,
  output logic            q_ready,
  input  logic [1:0]      q_channel,
  input  logic [RawW-1:0] q_raw,
  input  logic [RawW+7:0] q_sum,
  input  logic [7:0]      q_cnt,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [71:0]     out_data
);

  state_t state, state_next;
  logic [1:0]      ch;
  logic [RawW-1:0] raw, avg, mv, fmv;
  logic            clip;
  logic            start, done;
  logic [31:0]     num, quot;
  logic [15:0]     den, fs;
  logic [4:0]      bits;
  logic [31:0]     prod;
  logic [RawW-1:0] mv_sat;
  logic            mv_ovf;

  assign bits = (res_bits > 5'(ResLimit)) ? 5'(ResLimit) : res_bits;
  assign fs   = 16'((17'd1 << bits) - 17'd1);
  assign mv_ovf = quot[31:16] != '0;
  assign mv_sat = mv_ovf ? 16'hFFFF : quot[15:0];

  acma_divider #(.NUM_W(32), .DEN_W(16)) u_div (
    .clk(clk), .rst(rst), .start(start), .num(num), .den(den),
    .done(done), .quot(quot)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid) state_next = ST_AVG;
      ST_AVG:  if (done) state_next = ST_MV0;
      ST_MV0:  if (done || bits == '0) state_next = ST_MV1;
      ST_MV1:  if (done || bits == '0) state_next = ST_DONE;
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready   = state == ST_IDLE;
    out_valid = state == ST_DONE;
    out_data  = {5'd0, clip, fmv, avg, mv, raw, ch};
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // operand sequencing
  always_ff @(posedge clk) begin
    start <= 1'b0;
    prod  <= 32'(raw) * 32'(ref_mv);
    if (rst) begin
      start <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (q_valid) begin
          ch <= q_channel; raw <= q_raw;
          clip <= 1'b0;
          num <= 32'(q_sum); den <= 16'(q_cnt); start <= 1'b1;
        end
        ST_AVG: if (done) begin
          avg <= (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
          num <= prod; den <= fs; start <= bits != '0;
        end
        ST_MV0: begin
          if (bits == '0) begin
            mv <= '0;
          end else if (done) begin
            mv <= mv_sat; clip <= clip | mv_ovf;
          end
          if (done || bits == '0) begin
            num <= 32'(avg) * 32'(ref_mv); start <= bits != '0;
          end
        end
        ST_MV1: begin
          if (bits == '0) fmv <= '0;
          else if (done) begin
            fmv <= mv_sat; clip <= clip | mv_ovf;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/adc_channel_moving_average_mv.sv]
// ---------------------------------------------------------------------------
// adc_channel_moving_average_mv
// per channel moving average filter with millivolt scaling
// ---------------------------------------------------------------------------
// s_axis beat: channel and raw sample. m_axis beat: channel, raw echo,
// sample millivolts, filtered raw, filtered millivolts and clip flag.
// beats with a channel at or above CHANNELS are dropped without result.
// the front end reads the ring, then updates the running sum and parks
// the beat in a one entry queue; the back end runs three 32 step
// divisions on one shared divider and takes a new item only once the
// previous output beat has been accepted. with resolution zero the two
// millivolt divisions are skipped.
// reset clears sums, positions and fill counts, and loads the reference
// of 3300 mV and 12 bits. ring contents are not cleared.
// a stalled m_axis holds its beat; the front end may take and queue one
// more item meanwhile. the user must make apb writes only while idle;
// the block does not enforce it. pready is always high.
// ---------------------------------------------------------------------------
module adc_channel_moving_average_mv import acma_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // channel[1:0], raw_sample[17:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_channel[1:0], raw_echo[17:2], sample_millivolts[33:18],
  // filtered_raw[49:34], filtered_millivolts[65:50], millivolt_clipped[66]
  output logic [71:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [RefW-1:0] ref_mv;
  logic [ResW-1:0] res_bits;
  logic            qv, qr;
  logic [1:0]      qch;
  logic [RawW-1:0] qraw;
  logic [RawW+7:0] qsum;
  logic [7:0]      qcnt;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mv   <= 16'd3300;
      res_bits <= 5'd12;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'(RegRef * 4)) ref_mv <= pwdata[RefW-1:0];
      else if (paddr == 3'(RegRes * 4)) res_bits <= pwdata[ResW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == 3'(RegRef * 4)) prdata = 32'(ref_mv);
    else if (paddr == 3'(RegRes * 4)) prdata = 32'(res_bits);
  end

  acma_front #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_channel(s_axis_tdata[1:0]), .in_raw(s_axis_tdata[17:2]),
    .q_valid(qv), .q_ready(qr), .q_channel(qch), .q_raw(qraw),
    .q_sum(qsum), .q_cnt(qcnt)
  );

  acma_back u_back (
    .clk(clk), .rst(rst), .ref_mv(ref_mv), .res_bits(res_bits),
    .q_valid(qv), .q_ready(qr), .q_channel(qch), .q_raw(qraw),
    .q_sum(qsum), .q_cnt(qcnt),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata)
  );

endmodule
